// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL files; the motion magnitude smoother includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/ims_pkg.sv -----
// Types and constants of the IMU motion magnitude smoother.
package ims_pkg;

    localparam int AXIS_W       = 16;
    localparam int MOTION_W     = 17;
    localparam int GAIN_W       = 9;
    localparam int FRAC_W       = 8;
    localparam int SMOOTH_W     = MOTION_W + FRAC_W;
    localparam int ACCEL_SUM_W  = 34;
    localparam int GYRO_SUM_W   = 32;
    localparam int GYRO_RAD_W   = GYRO_SUM_W + FRAC_W;
    localparam int ACCEL_ROOT_W = ACCEL_SUM_W / 2;
    localparam int GYRO_ROOT_W  = GYRO_RAD_W / 2;
    localparam int GYRO_DIV     = 45;

    localparam logic [GAIN_W-1:0]   GAIN_ONE   = 9'd256;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = 9'd72;
    localparam logic [MOTION_W-1:0] MOTION_MAX = '1;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = {MOTION_MAX, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic                     restart;
    } sample_t;

    typedef struct packed {
        logic [MOTION_W-1:0] motion;
        logic                first_sample;
    } result_t;

endpackage

// ----- sv/ims_sumsq.sv -----
// Bit-serial sum of squares of three unsigned magnitudes.
module ims_sumsq #(
    parameter int MAG_W = 16,
    parameter int SUM_W = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0][MAG_W-1:0] mags,
    output logic                  busy,
    output logic [SUM_W-1:0]      sum
);

    localparam int PROD_W = 2 * MAG_W;
    localparam int BIT_CW = $clog2(MAG_W);
    localparam logic [BIT_CW-1:0] BIT_LAST = BIT_CW'(MAG_W - 1);
    localparam logic [1:0] AXIS_LAST = 2'd2;

    logic [2:0][MAG_W-1:0] mags_reg;
    logic [PROD_W-1:0]     mcand_reg;
    logic [MAG_W-1:0]      mplier_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [1:0]            axis_reg;
    logic [BIT_CW-1:0]     bit_reg;
    logic                  busy_reg;

    logic [1:0]       axis_next;
    logic [SUM_W-1:0] acc_next;

    assign axis_next = axis_reg + 2'd1;
    assign acc_next  = mplier_reg[0] ? acc_reg + SUM_W'(mcand_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mags_reg   <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
            axis_reg   <= '0;
            bit_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else if (start)
        begin
            mags_reg   <= mags;
            mcand_reg  <= PROD_W'(mags[0]);
            mplier_reg <= mags[0];
            acc_reg    <= '0;
            axis_reg   <= '0;
            bit_reg    <= '0;
            busy_reg   <= 1'b1;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            if (bit_reg == BIT_LAST)
            begin
                bit_reg <= '0;
                if (axis_reg == AXIS_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    // load the next axis
                    axis_reg   <= axis_next;
                    mcand_reg  <= PROD_W'(mags_reg[axis_next]);
                    mplier_reg <= mags_reg[axis_next];
                end
            end
            else
            begin
                bit_reg    <= bit_reg + BIT_CW'(1);
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
        end
    end

    assign busy = busy_reg;
    assign sum  = acc_reg;

endmodule

// ----- sv/ims_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
module ims_sqrt #(
    parameter int RAD_W = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [RAD_W-1:0]       radicand,
    output logic                   busy,
    output logic [RAD_W/2-1:0]     root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // bring down the next two radicand bits and try 4*root+1
    assign rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign fits      = rem_sh >= trial;
    assign rem_next  = fits ? rem_sh - trial : rem_sh;
    assign root_next = {root_reg[ROOT_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CNT_W'(ROOT_W - 1);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- sv/ims_cdiv.sv -----
// Restoring division by a constant, one quotient bit per cycle.
module ims_cdiv #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR    = 45
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int REM_W = $clog2(DIVISOR) + 1;
    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [REM_W-1:0] DIV_C = REM_W'(DIVISOR);

    logic [DIVIDEND_W-1:0] dq_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    logic [REM_W-1:0] part;
    logic             ge;

    // remainder stays below the divisor, so the shifted value fits
    assign part = {rem_reg[REM_W-2:0], dq_reg[DIVIDEND_W-1]};
    assign ge   = part >= DIV_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_reg   <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            dq_reg   <= dividend;
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            // shift dividend out at the top, quotient in at the bottom
            dq_reg  <= {dq_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? part - DIV_C : part;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

// ----- sv/imu_motion_magnitude_smoother.sv -----
// IMU motion magnitude smoother: one item is one IMU sample and gives one result item.
// The first sample after reset or restart only stores the acceleration vector and answers
// motion 0 with first_sample set. Every later sample gives its result after the bit-serial
// squaring of the three axis magnitudes, the square roots, the bit-serial divide by 45 of
// the gyro length, the bit-serial gain multiply of the smoothing filter and the sequencing
// states. One item is in work at a time; the next item is accepted the cycle after the
// result is loaded into the output register. A result that waits in a stalled output
// register holds the block until it is taken.
module imu_motion_magnitude_smoother (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            smoothing_gain_we,
    input  logic [ims_pkg::GAIN_W-1:0]      smoothing_gain_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  ims_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output ims_pkg::result_t                result
);

`include "assert_macros.svh"

    localparam int DIFF_W = ims_pkg::SMOOTH_W + 1;
    localparam int PROD_W = DIFF_W + ims_pkg::GAIN_W;
    localparam int STEP_W = PROD_W - ims_pkg::FRAC_W;
    localparam int NEW_W  = STEP_W + 1;
    localparam int INST_W = ims_pkg::GYRO_ROOT_W + 1;
    localparam int FCNT_W = $clog2(ims_pkg::GAIN_W);
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (ims_pkg::FRAC_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_WAIT,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_FILT,
        ST_FILT_RUN,
        ST_UPD,
        ST_OUT
    } state_t;

    state_t                                state_reg;
    logic [ims_pkg::GAIN_W-1:0]            gain_reg;
    logic signed [ims_pkg::AXIS_W-1:0]     prev_x_reg;
    logic signed [ims_pkg::AXIS_W-1:0]     prev_y_reg;
    logic signed [ims_pkg::AXIS_W-1:0]     prev_z_reg;
    logic                                  have_prev_reg;
    logic [ims_pkg::SMOOTH_W-1:0]          smoothed_reg;
    logic                                  first_reg;
    logic signed [PROD_W-1:0]              mcand_reg;
    logic signed [PROD_W-1:0]              acc_reg;
    logic [ims_pkg::GAIN_W-1:0]            gain_sh_reg;
    logic [FCNT_W-1:0]                     filt_cnt_reg;
    logic                                  result_valid_reg;
    ims_pkg::result_t                      result_reg;

    logic                                  accept;
    logic                                  priming;
    logic [2:0][ims_pkg::AXIS_W-1:0]       accel_mags;
    logic [2:0][ims_pkg::AXIS_W-1:0]       gyro_mags;
    logic                                  acc_sq_busy;
    logic                                  gyr_sq_busy;
    logic [ims_pkg::ACCEL_SUM_W-1:0]       acc_sum;
    logic [ims_pkg::GYRO_SUM_W-1:0]        gyr_sum;
    logic                                  acc_rt_busy;
    logic                                  gyr_rt_busy;
    logic [ims_pkg::ACCEL_ROOT_W-1:0]      acc_root;
    logic [ims_pkg::GYRO_ROOT_W-1:0]       gyr_root;
    logic                                  div_busy;
    logic [ims_pkg::GYRO_ROOT_W-1:0]       gyr_q10;
    logic [INST_W-1:0]                     inst_sum;
    logic [ims_pkg::MOTION_W-1:0]          inst;
    logic signed [DIFF_W-1:0]              diff;
    logic [ims_pkg::GAIN_W-1:0]            gain_eff;
    logic signed [PROD_W-1:0]              acc_rnd;
    logic signed [STEP_W-1:0]              step;
    logic signed [NEW_W-1:0]               new_sum;
    logic [ims_pkg::SMOOTH_W-1:0]          smoothed_next;
    logic [ims_pkg::SMOOTH_W:0]            motion_rnd;
    logic [ims_pkg::MOTION_W:0]            motion_full;
    ims_pkg::result_t                      result_next;

    function automatic logic [ims_pkg::AXIS_W-1:0] mag17(input logic signed [ims_pkg::AXIS_W:0] v);
        logic signed [ims_pkg::AXIS_W:0] a;
        a = v[ims_pkg::AXIS_W] ? -v : v;
        return a[ims_pkg::AXIS_W-1:0];
    endfunction

    assign sample_stall = state_reg != ST_IDLE;
    assign accept       = sample_valid && !sample_stall;
    assign priming      = sample.restart || !have_prev_reg;

    assign accel_mags[0] = mag17({sample.accel_x[ims_pkg::AXIS_W-1], sample.accel_x}
                                 - {prev_x_reg[ims_pkg::AXIS_W-1], prev_x_reg});
    assign accel_mags[1] = mag17({sample.accel_y[ims_pkg::AXIS_W-1], sample.accel_y}
                                 - {prev_y_reg[ims_pkg::AXIS_W-1], prev_y_reg});
    assign accel_mags[2] = mag17({sample.accel_z[ims_pkg::AXIS_W-1], sample.accel_z}
                                 - {prev_z_reg[ims_pkg::AXIS_W-1], prev_z_reg});
    assign gyro_mags[0]  = mag17({sample.gyro_x[ims_pkg::AXIS_W-1], sample.gyro_x});
    assign gyro_mags[1]  = mag17({sample.gyro_y[ims_pkg::AXIS_W-1], sample.gyro_y});
    assign gyro_mags[2]  = mag17({sample.gyro_z[ims_pkg::AXIS_W-1], sample.gyro_z});

    ims_sumsq #(
        .MAG_W (ims_pkg::AXIS_W),
        .SUM_W (ims_pkg::ACCEL_SUM_W)
    ) u_acc_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !priming),
        .mags  (accel_mags),
        .busy  (acc_sq_busy),
        .sum   (acc_sum)
    );

    ims_sumsq #(
        .MAG_W (ims_pkg::AXIS_W),
        .SUM_W (ims_pkg::GYRO_SUM_W)
    ) u_gyr_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !priming),
        .mags  (gyro_mags),
        .busy  (gyr_sq_busy),
        .sum   (gyr_sum)
    );

    ims_sqrt #(
        .RAD_W (ims_pkg::ACCEL_SUM_W)
    ) u_acc_rt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_ROOT),
        .radicand (acc_sum),
        .busy     (acc_rt_busy),
        .root     (acc_root)
    );

    ims_sqrt #(
        .RAD_W (ims_pkg::GYRO_RAD_W)
    ) u_gyr_rt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_ROOT),
        .radicand ({gyr_sum, {ims_pkg::FRAC_W{1'b0}}}),
        .busy     (gyr_rt_busy),
        .root     (gyr_root)
    );

    ims_cdiv #(
        .DIVIDEND_W (ims_pkg::GYRO_ROOT_W),
        .DIVISOR    (ims_pkg::GYRO_DIV)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV),
        .dividend (gyr_root),
        .busy     (div_busy),
        .quotient (gyr_q10)
    );

    // instantaneous motion, saturated before the filter
    assign inst_sum = INST_W'(acc_root) + INST_W'(gyr_q10);
    assign inst     = (inst_sum > INST_W'(ims_pkg::MOTION_MAX)) ? ims_pkg::MOTION_MAX
                                                              : inst_sum[ims_pkg::MOTION_W-1:0];
    assign diff     = $signed({1'b0, inst, {ims_pkg::FRAC_W{1'b0}}})
                      - $signed({1'b0, smoothed_reg});
    assign gain_eff = (gain_reg > ims_pkg::GAIN_ONE) ? ims_pkg::GAIN_ONE : gain_reg;

    // new = old + round((inst - old) * gain / 256)
    assign acc_rnd = acc_reg + $signed(RND_HALF);
    assign step    = acc_rnd[PROD_W-1:ims_pkg::FRAC_W];
    assign new_sum = $signed({1'b0, (NEW_W-1)'(smoothed_reg)}) + $signed({step[STEP_W-1], step});

    always_comb
    begin
        priority if (new_sum[NEW_W-1])
        begin
            smoothed_next = '0;
        end
        else if (new_sum > $signed({1'b0, (NEW_W-1)'(ims_pkg::SMOOTH_MAX)}))
        begin
            smoothed_next = ims_pkg::SMOOTH_MAX;
        end
        else
        begin
            smoothed_next = new_sum[ims_pkg::SMOOTH_W-1:0];
        end
    end

    assign motion_rnd  = {1'b0, smoothed_reg} + (ims_pkg::SMOOTH_W + 1)'(RND_HALF);
    assign motion_full = motion_rnd[ims_pkg::SMOOTH_W:ims_pkg::FRAC_W];

    always_comb
    begin
        result_next.first_sample = first_reg;
        priority if (first_reg)
        begin
            result_next.motion = '0;
        end
        else if (motion_full[ims_pkg::MOTION_W])
        begin
            result_next.motion = ims_pkg::MOTION_MAX;
        end
        else
        begin
            result_next.motion = motion_full[ims_pkg::MOTION_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gain_reg         <= ims_pkg::GAIN_RESET;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_z_reg       <= '0;
            have_prev_reg    <= 1'b0;
            smoothed_reg     <= '0;
            first_reg        <= 1'b0;
            mcand_reg        <= '0;
            acc_reg          <= '0;
            gain_sh_reg      <= '0;
            filt_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (smoothing_gain_we)
            begin
                gain_reg <= smoothing_gain_data;
            end
            // drop the taken item unless a new one loads in the same cycle
            if (result_valid_reg && !result_stall && state_reg != ST_OUT)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prev_x_reg    <= sample.accel_x;
                        prev_y_reg    <= sample.accel_y;
                        prev_z_reg    <= sample.accel_z;
                        have_prev_reg <= 1'b1;
                        first_reg     <= priming;
                        if (sample.restart)
                        begin
                            smoothed_reg <= '0;
                        end
                        state_reg <= priming ? ST_OUT : ST_SQ_WAIT;
                    end
                end
                ST_SQ_WAIT:
                begin
                    if (!acc_sq_busy && !gyr_sq_busy)
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT:
                begin
                    if (!acc_rt_busy && !gyr_rt_busy)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_FILT;
                    end
                end
                ST_FILT:
                begin
                    mcand_reg    <= {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
                    acc_reg      <= '0;
                    gain_sh_reg  <= gain_eff;
                    filt_cnt_reg <= FCNT_W'(ims_pkg::GAIN_W - 1);
                    state_reg    <= ST_FILT_RUN;
                end
                ST_FILT_RUN:
                begin
                    // add the shifted difference for each set gain bit
                    if (gain_sh_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg   <= mcand_reg <<< 1;
                    gain_sh_reg <= gain_sh_reg >> 1;
                    if (filt_cnt_reg == '0)
                    begin
                        state_reg <= ST_UPD;
                    end
                    else
                    begin
                        filt_cnt_reg <= filt_cnt_reg - FCNT_W'(1);
                    end
                end
                ST_UPD:
                begin
                    smoothed_reg <= smoothed_next;
                    state_reg    <= ST_OUT;
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg       <= result_next;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_first_zero, result_valid && result.first_sample, result.motion == '0,
                    "priming item with nonzero motion")
    `ASSERT_ALWAYS(a_smooth_max, smoothed_reg <= ims_pkg::SMOOTH_MAX, "filter value above range")
    `ASSERT_NEXT(a_prime_path, accept && priming, state_reg == ST_OUT,
                 "priming item entered the datapath")
    `ASSERT_IMPLIES(a_units_idle, state_reg == ST_ROOT || state_reg == ST_DIV,
                    !acc_sq_busy && !gyr_sq_busy, "square unit busy past its stage")

endmodule
